// ----- design/lkvc_pkg.sv -----
// shared types and constants for the lru key-value cache
package lkvc_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int KEY_W           = 31;
    localparam int VAL_W           = 31;
    localparam int RD_W            = 32;
    localparam int CAP_W           = 5;

    localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
    localparam logic [RD_W-1:0]  MISS_VALUE = '1;

    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    typedef struct packed {
        logic             func;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic             was_present;
        logic [RD_W-1:0]  read_value;
        logic             did_evict;
        logic [KEY_W-1:0] evicted_key;
    } rsp_t;

endpackage

// ----- design/lkvc_table.sv -----
// entry table: key match, recency ranks, victim choice and state update
module lkvc_table #(
    parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [lkvc_pkg::CAP_W-1:0] capacity,
    input  logic                       req_fire,
    input  lkvc_pkg::req_t             req,
    output lkvc_pkg::rsp_t             rsp
);
    import lkvc_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

    logic [KEY_W-1:0]       key_mem [MAX_ENTRIES];
    logic [VAL_W-1:0]       val_mem [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [MAX_ENTRIES-1:0] valid_next;
    logic [AW-1:0]          age_reg [MAX_ENTRIES];
    logic [AW-1:0]          age_next [MAX_ENTRIES];
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;

    logic [MAX_ENTRIES-1:0] hit_vec;
    logic [MAX_ENTRIES-1:0] vic_vec;
    logic [MAX_ENTRIES-1:0] free_n;
    logic [MAX_ENTRIES-1:0] free_oh;
    logic [MAX_ENTRIES-1:0] ins_oh;
    logic [MAX_ENTRIES-1:0] wr_oh;
    logic                   hit;
    logic                   full;
    logic [VAL_W-1:0]       hit_value;
    logic [AW-1:0]          hit_age;
    logic [AW-1:0]          last_age;
    logic [KEY_W-1:0]       vic_key;
    logic [CW-1:0]          eff_cap;

    // effective capacity clamped to 1 .. MAX_ENTRIES
    always_comb
    begin
        if (capacity == '0)
            eff_cap = CW'(1);
        else if (32'(capacity) > 32'(MAX_ENTRIES))
            eff_cap = MAX_CNT;
        else
            eff_cap = CW'(capacity);
    end

    assign full     = count_reg >= eff_cap;
    assign last_age = AW'(count_reg - CW'(1));
    assign free_n   = ~valid_reg;
    assign free_oh  = free_n & (~free_n + MAX_ENTRIES'(1));
    assign ins_oh   = full ? vic_vec : free_oh;

    // parallel match; keys are unique so the hit vector has at most one bit set
    always_comb
    begin
        hit_value = '0;
        hit_age   = '0;
        vic_key   = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            hit_vec[i] = valid_reg[i] && (key_mem[i] == req.key);
            vic_vec[i] = valid_reg[i] && (age_reg[i] == last_age);
            if (hit_vec[i])
            begin
                hit_value = hit_value | val_mem[i];
                hit_age   = hit_age | age_reg[i];
            end
            if (vic_vec[i])
                vic_key = vic_key | key_mem[i];
        end
        hit = |hit_vec;
    end

    always_comb
    begin
        valid_next = valid_reg;
        age_next   = age_reg;
        count_next = count_reg;
        wr_oh      = '0;
        if (req.func == FUNC_PUT)
            wr_oh = hit ? hit_vec : ins_oh;
        if (hit)
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                if (valid_reg[i] && (age_reg[i] < hit_age))
                    age_next[i] = AW'(age_reg[i] + 1'b1);
                if (hit_vec[i])
                    age_next[i] = '0;
            end
        end
        else if (req.func == FUNC_PUT)
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                if (ins_oh[i])
                begin
                    valid_next[i] = 1'b1;
                    age_next[i]   = '0;
                end
                else if (valid_reg[i])
                begin
                    age_next[i] = AW'(age_reg[i] + 1'b1);
                end
            end
            if (!full)
                count_next = CW'(count_reg + 1'b1);
        end
    end

    always_comb
    begin
        rsp.was_present = hit;
        if (req.func == FUNC_PUT)
            rsp.read_value = {1'b0, req.value};
        else if (hit)
            rsp.read_value = {1'b0, hit_value};
        else
            rsp.read_value = MISS_VALUE;
        rsp.did_evict   = (req.func == FUNC_PUT) && !hit && full;
        rsp.evicted_key = rsp.did_evict ? vic_key : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++)
                age_reg[i] <= '0;
        end
        else if (req_fire)
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            age_reg   <= age_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (req_fire && wr_oh[i])
            begin
                key_mem[i] <= req.key;
                val_mem[i] <= req.value;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(count_reg))
        else $error("fill count disagrees with valid slots");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("fill count above table size");

    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit_vec))
        else $error("key present in more than one slot");

    a_victim_unique: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && (req.func == FUNC_PUT) && !hit && full) |-> $onehot(vic_vec))
        else $error("no unique least recent slot on eviction");
`endif

endmodule

// ----- design/lru_key_value_cache_unit.sv -----
// top level of the lru key-value cache: channels, capacity register, pipeline registers
//
// Fully associative key-value cache with least-recently-used replacement.
// Request channel: in_valid/in_ready with func (0 get, 1 put), lookup_key
// and write_value. Result channel: out_valid/out_ready with was_present,
// read_value (-1 on a get miss), did_evict and evicted_key.
// capacity_in_use is written whenever capacity_wr_en is high; write it only
// while no request is in flight. Values of 0 act as 1, values above
// MAX_ENTRIES act as MAX_ENTRIES.
// A request transfer is registered in the input register; from there it is
// looked up and applied to the table, and its result goes to the output
// register that drives out_valid. Throughput: one request per cycle while
// out_ready does not stall the result, set by the combinational match, rank
// update and victim select over all entries.
// A stalled result holds in the output register; one more request waits in
// the input register, then in_ready drops until out_ready returns.
// Reset clears all valid marks, ranks and the fill count, sets the capacity
// to 16 and empties both pipeline registers. No clearing pass is needed.
module lru_key_value_cache_unit #(
    parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             capacity_wr_en,
    input  logic [lkvc_pkg::CAP_W-1:0]       capacity_in_use,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             func,
    input  logic [lkvc_pkg::KEY_W-1:0]       lookup_key,
    input  logic [lkvc_pkg::VAL_W-1:0]       write_value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             was_present,
    output logic signed [lkvc_pkg::RD_W-1:0] read_value,
    output logic                             did_evict,
    output logic [lkvc_pkg::KEY_W-1:0]       evicted_key
);
    import lkvc_pkg::*;

    logic [CAP_W-1:0] cap_reg;
    logic             req_valid_reg;
    req_t             req_reg;
    logic             out_valid_reg;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;
    logic             advance;
    logic             req_fire;

    assign advance  = !out_valid_reg || out_ready;
    assign req_fire = req_valid_reg && advance;
    assign in_ready = !req_valid_reg || advance;

    lkvc_table #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .capacity(cap_reg),
        .req_fire(req_fire),
        .req     (req_reg),
        .rsp     (rsp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CAP_RESET;
        else if (capacity_wr_en)
            cap_reg <= capacity_in_use;
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid_reg <= 1'b0;
        else if (in_ready)
            req_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg.func  <= func;
            req_reg.key   <= lookup_key;
            req_reg.value <= write_value;
        end
    end

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= req_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
            rsp_reg <= rsp_next;
    end

    assign out_valid   = out_valid_reg;
    assign was_present = rsp_reg.was_present;
    assign read_value  = signed'(rsp_reg.read_value);
    assign did_evict   = rsp_reg.did_evict;
    assign evicted_key = rsp_reg.evicted_key;

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for the lru key-value cache unit
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lkvc_pkg::*;

    localparam int          CACHE_LINES     = MAX_ENTRIES_DEF;
    localparam int          HOLD_OFF_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT     = 200000;

    logic             clk             = 1'b0;
    logic             rst_n           = 1'b0;
    logic             capacity_wr_en  = 1'b0;
    logic [CAP_W-1:0] capacity_in_use = '0;
    logic             in_valid        = 1'b0;
    logic             in_ready;
    logic             func            = FUNC_GET;
    logic [KEY_W-1:0] lookup_key      = '0;
    logic [VAL_W-1:0] write_value     = '0;
    logic             out_valid;
    logic             out_ready       = 1'b0;
    logic             was_present;
    logic signed [RD_W-1:0] read_value;
    logic             did_evict;
    logic [KEY_W-1:0] evicted_key;

    // shadow copy of the cache table
    logic [KEY_W-1:0] line_key   [CACHE_LINES];
    logic [VAL_W-1:0] line_value [CACHE_LINES];
    bit               line_valid [CACHE_LINES];
    int unsigned      line_rank  [CACHE_LINES];
    int unsigned      line_count  = 0;
    logic [CAP_W-1:0] cap_setting = CAP_RESET;

    rsp_t        expected_results [$];
    int          error_count    = 0;
    int unsigned cycle_count    = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    bit          hold_off_request = 1'b0;

    lru_key_value_cache_unit u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .capacity_wr_en  (capacity_wr_en),
        .capacity_in_use (capacity_in_use),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .lookup_key      (lookup_key),
        .write_value     (write_value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .was_present     (was_present),
        .read_value      (read_value),
        .did_evict       (did_evict),
        .evicted_key     (evicted_key)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[lru_key_value_cache_unit] ERROR");
            $finish;
        end
    end

    function automatic void make_most_recent(input int slot);
        for (int i = 0; i < CACHE_LINES; i++)
        begin
            if (line_valid[i] && line_rank[i] < line_rank[slot])
                line_rank[i]++;
        end
        line_rank[slot] = 0;
    endfunction

    function automatic rsp_t lru_access(input logic op, input logic [KEY_W-1:0] key,
                                        input logic [VAL_W-1:0] value);
        rsp_t        reply;
        int          hit;
        int          slot;
        int unsigned fill_limit;
        reply = '0;
        hit   = -1;
        slot  = -1;
        for (int i = CACHE_LINES - 1; i >= 0; i--)
        begin
            if (line_valid[i] && line_key[i] == key)
                hit = i;
        end
        reply.was_present = (hit >= 0);
        if (op == FUNC_GET)
        begin
            if (hit >= 0)
            begin
                make_most_recent(hit);
                reply.read_value = {1'b0, line_value[hit]};
            end
            else
                reply.read_value = MISS_VALUE;
            return reply;
        end
        reply.read_value = {1'b0, value};
        if (hit >= 0)
        begin
            line_value[hit] = value;
            make_most_recent(hit);
            return reply;
        end
        fill_limit = (cap_setting == 0) ? 1 :
                     ((cap_setting > CACHE_LINES) ? CACHE_LINES : cap_setting);
        if (line_count >= fill_limit)
        begin
            for (int i = 0; i < CACHE_LINES; i++)
            begin
                if (line_valid[i] && (slot < 0 || line_rank[i] > line_rank[slot]))
                    slot = i;
            end
        end
        if (slot >= 0)
        begin
            reply.did_evict   = 1'b1;
            reply.evicted_key = line_key[slot];
            line_valid[slot]  = 1'b0;
        end
        else
        begin
            for (int i = CACHE_LINES - 1; i >= 0; i--)
            begin
                if (!line_valid[i])
                    slot = i;
            end
            line_count++;
        end
        for (int i = 0; i < CACHE_LINES; i++)
        begin
            if (line_valid[i])
                line_rank[i]++;
        end
        line_key[slot]   = key;
        line_value[slot] = value;
        line_valid[slot] = 1'b1;
        line_rank[slot]  = 0;
        return reply;
    endfunction

    task automatic send_request(input logic op, input logic [KEY_W-1:0] key,
                                input logic [VAL_W-1:0] value);
        logic accepted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        func        <= op;
        lookup_key  <= key;
        write_value <= value;
        do
        begin
            @(negedge clk);
            accepted = in_ready;
            @(posedge clk);
        end
        while (!accepted);
        expected_results.push_back(lru_access(op, key, value));
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] setting);
        capacity_wr_en  <= 1'b1;
        capacity_in_use <= setting;
        @(posedge clk);
        capacity_wr_en  <= 1'b0;
        cap_setting = setting;
    endtask

    task automatic test_get_put_basics();
        send_request(FUNC_GET, 31'd1, 31'h1234_5678);
        send_request(FUNC_PUT, 31'd1, '0);
        send_request(FUNC_PUT, '1, '1);
        send_request(FUNC_GET, 31'd1, '1);
        send_request(FUNC_GET, '1, '0);
        send_request(FUNC_PUT, 31'd1, 31'h5555_5555);
        send_request(FUNC_GET, 31'd1, '0);
        // key zero is an ordinary key
        send_request(FUNC_PUT, 31'd0, 31'h2AAA_AAAA);
        send_request(FUNC_GET, 31'd0, '0);
    endtask

    task automatic test_capacity_limits();
        // zero acts as one, the fill stays above it and evicts one per put
        wait_for_results();
        write_capacity(5'd0);
        send_request(FUNC_PUT, 31'h4000_0000, 31'd1);
        send_request(FUNC_PUT, 31'd2, 31'd2);
        send_request(FUNC_PUT, 31'd3, 31'd3);
        // over-range acts as the full table
        wait_for_results();
        write_capacity(5'd31);
        send_request(FUNC_PUT, 31'd5, 31'd5);
        send_request(FUNC_PUT, 31'd6, 31'd6);
        send_request(FUNC_PUT, 31'd7, 31'd7);
        send_request(FUNC_GET, 31'd1, '0);
        // capacity lowered below the fill
        wait_for_results();
        write_capacity(5'd2);
        send_request(FUNC_PUT, 31'd8, 31'h7FFF_0000);
        send_request(FUNC_GET, 31'd3, '0);
        send_request(FUNC_PUT, 31'd9, 31'h0000_FFFF);
    endtask

    task automatic test_backpressure();
        wait_for_results();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_request = 1'b1;
        for (int i = 0; i < 8; i++)
            send_request(FUNC_PUT, 31'(100 + i), 31'($urandom));
        for (int i = 0; i < 8; i++)
            send_request(FUNC_GET, 31'(100 + i), '0);
        wait_for_results();
    endtask

    task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct);
        logic [KEY_W-1:0] key_pool [32];
        int unsigned      pool_size;
        int unsigned      fill_limit;
        logic [CAP_W-1:0] setting;
        logic             op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int seg = 0; seg < 4; seg++)
        begin
            case (seg)
                0:       setting = 5'($urandom_range(2, 15));
                1:       setting = CAP_RESET;
                2:       setting = 5'd1;
                default: setting = 5'($urandom_range(17, 31));
            endcase
            fill_limit = (setting > CACHE_LINES) ? CACHE_LINES : setting;
            pool_size  = fill_limit + $urandom_range(1, 8);
            for (int i = 0; i < pool_size; i++)
                key_pool[i] = KEY_W'($urandom);
            wait_for_results();
            write_capacity(setting);
            for (int n = 0; n < 116; n++)
            begin
                op = ($urandom_range(99) < 55) ? FUNC_PUT : FUNC_GET;
                if ($urandom_range(99) < 8)
                    key = KEY_W'($urandom);
                else
                    key = key_pool[$urandom_range(pool_size - 1)];
                case ($urandom_range(9))
                    0:       value = '0;
                    1:       value = '1;
                    default: value = VAL_W'($urandom);
                endcase
                send_request(op, key, value);
                if ($urandom_range(63) == 0)
                    wait_for_results();
            end
        end
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        rsp_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("transfer with no result outstanding: read_value %0d", read_value);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (was_present !== want.was_present)
                    begin
                        $error("was_present: expected %0d, got %0d", want.was_present, was_present);
                        error_count++;
                    end
                    if (read_value !== want.read_value)
                    begin
                        $error("read_value: expected %0d, got %0d",
                               $signed(want.read_value), read_value);
                        error_count++;
                    end
                    if (did_evict !== want.did_evict)
                    begin
                        $error("did_evict: expected %0d, got %0d", want.did_evict, did_evict);
                        error_count++;
                    end
                    if (evicted_key !== want.evicted_key)
                    begin
                        $error("evicted_key: expected %0d, got %0d", want.evicted_key, evicted_key);
                        error_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_get_put_basics();
        test_capacity_limits();
        test_backpressure();
        test_random_traffic(0, 0);
        test_random_traffic(51, 0);
        test_random_traffic(0, 51);
        test_random_traffic(33, 33);
        wait_for_results();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("[lru_key_value_cache_unit] OK");
        else
            $display("[lru_key_value_cache_unit] ERROR");
        $finish;
    end

endmodule
